FILE: hdl/cbpa_pkg.sv
`default_nettype none

package cbpa_pkg;

    localparam int POOL_BITS   = 20;
    localparam int HANDLE_BITS = 16;

    localparam logic [POOL_BITS-1:0] HDR_BYTES  = 20'h00018;
    localparam logic [POOL_BITS-1:0] ALIGN_MASK = 20'h00003;
    localparam logic [POOL_BITS-1:0] POOL_RESET = 20'h10000;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_COMPACT = 2'd2,
        CMD_RSVD    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SPACE   = 2'd1,
        STAT_TABLE_FULL = 2'd2,
        STAT_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE_SCAN,
        S_FREE_SHIFT,
        S_FREE_DONE,
        S_FREE_MISS,
        S_COMP_SCAN,
        S_COMP_TURN,
        S_COMP_EMIT,
        S_CLOSE
    } state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LATCH,
        DP_ALLOC,
        DP_FREE_CHK,
        DP_SHIFT,
        DP_FREE_DONE,
        DP_NOT_FOUND,
        DP_COMP_CHK,
        DP_COMP_EMIT,
        DP_CLOSE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_t;

    typedef struct packed {
        logic empty;
        logic at_last;
        logic at_second_last;
        logic match;
    } dp_stat_t;

    typedef struct packed {
        logic [POOL_BITS-1:0]   off;
        logic [POOL_BITS-1:0]   size;
        logic [HANDLE_BITS-1:0] owner;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/compacting_block_pool_allocator.sv
// Allocate: busy covers the single ALLOC state, from which the result strobe is registered.
// Free: busy while the scan looks for the entry; when a later entry must move down, a shift
// pass moves each later entry down one place and a finish state closes the request.
// Compact: a scan pass, a turnaround state, an emit pass and a closing state.
// Each pass visits one table entry per cycle; a new request is taken once busy falls.
// The receiver cannot stall results. Reset (rst_n low, asynchronous) empties the table.
`default_nettype none

module compacting_block_pool_allocator #(
    parameter int MAX_BLOCKS  = 32,
    parameter int OFFSET_BITS = 20
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [15:0] handle,
    input  wire logic [19:0] request_bytes,
    input  wire logic        cfg_we,
    input  wire logic [19:0] cfg_wdata,
    output logic             result_strobe,
    output logic [1:0]       status,
    output logic [15:0]      result_handle,
    output logic [19:0]      data_offset,
    output logic [19:0]      free_bytes,
    output logic [19:0]      used_bytes,
    output logic [19:0]      contiguous_bytes,
    output logic             last
);

    // The table depth sets both the entry address and the width of the fill count.
    localparam int ADDR_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);

    cbpa_pkg::ctrl_t    ctrl;
    cbpa_pkg::dp_stat_t stat;
    logic [ADDR_W-1:0]  idx;
    logic [ADDR_W-1:0]  rd_addr;

    // The controller sequences each request over the table one entry per cycle.
    cbpa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .busy    (busy),
        .ctrl    (ctrl),
        .idx     (idx),
        .rd_addr (rd_addr)
    );

    // The datapath holds the table memory, the counters and the result register.
    cbpa_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .handle           (handle),
        .request_bytes    (request_bytes),
        .ctrl             (ctrl),
        .idx              (idx),
        .rd_addr          (rd_addr),
        .stat             (stat),
        .result_strobe    (result_strobe),
        .status           (status),
        .result_handle    (result_handle),
        .data_offset      (data_offset),
        .free_bytes       (free_bytes),
        .used_bytes       (used_bytes),
        .contiguous_bytes (contiguous_bytes),
        .last             (last)
    );

    // The closing result of a request is never directly followed by another result.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last) |=> !result_strobe)
        else $error("result right after a closing result");

endmodule

`default_nettype wire

FILE: hdl/cbpa_ctrl.sv
`default_nettype none

module cbpa_ctrl #(
    parameter int MAX_BLOCKS = 32,
    parameter int ADDR_W     = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         command,
    input  wire cbpa_pkg::dp_stat_t stat,
    output logic                    busy,
    output cbpa_pkg::ctrl_t         ctrl,
    output logic [ADDR_W-1:0]       idx,
    output logic [ADDR_W-1:0]       rd_addr
);

    cbpa_pkg::state_t  state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W:0]   rd_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbpa_pkg::S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            cbpa_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    unique case (cbpa_pkg::cmd_t'(command))
                        cbpa_pkg::CMD_ALLOC:   state_next = cbpa_pkg::S_ALLOC;
                        cbpa_pkg::CMD_FREE:    state_next = stat.empty ?
                                               cbpa_pkg::S_FREE_MISS : cbpa_pkg::S_FREE_SCAN;
                        cbpa_pkg::CMD_COMPACT: state_next = stat.empty ?
                                               cbpa_pkg::S_CLOSE : cbpa_pkg::S_COMP_SCAN;
                        default:               state_next = cbpa_pkg::S_CLOSE;
                    endcase
                end
            end
            cbpa_pkg::S_FREE_SCAN:
            begin
                if (stat.match)
                    state_next = stat.at_last ? cbpa_pkg::S_IDLE : cbpa_pkg::S_FREE_SHIFT;
                else if (stat.at_last)
                    state_next = cbpa_pkg::S_IDLE;
                else
                    idx_next = idx_reg + ADDR_W'(1);
            end
            cbpa_pkg::S_FREE_SHIFT:
            begin
                if (stat.at_second_last)
                    state_next = cbpa_pkg::S_FREE_DONE;
                else
                    idx_next = idx_reg + ADDR_W'(1);
            end
            cbpa_pkg::S_COMP_SCAN:
            begin
                if (stat.at_last)
                begin
                    state_next = cbpa_pkg::S_COMP_TURN;
                    idx_next   = '0;
                end
                else
                    idx_next = idx_reg + ADDR_W'(1);
            end
            cbpa_pkg::S_COMP_TURN:
            begin
                state_next = cbpa_pkg::S_COMP_EMIT;
            end
            cbpa_pkg::S_COMP_EMIT:
            begin
                if (stat.at_last)
                    state_next = cbpa_pkg::S_CLOSE;
                else
                    idx_next = idx_reg + ADDR_W'(1);
            end
            cbpa_pkg::S_ALLOC,
            cbpa_pkg::S_FREE_DONE,
            cbpa_pkg::S_FREE_MISS,
            cbpa_pkg::S_CLOSE:
            begin
                state_next = cbpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cbpa_pkg::S_IDLE;
            end
        endcase
    end

    // The shift pass reads one entry ahead of the one it writes.
    always_comb
    begin
        rd_wide = {1'b0, idx_next};
        if (state_next == cbpa_pkg::S_FREE_SHIFT)
            rd_wide = {1'b0, idx_next} + (ADDR_W+1)'(1);
        if (rd_wide >= (ADDR_W+1)'(MAX_BLOCKS))
            rd_addr = '0;
        else
            rd_addr = rd_wide[ADDR_W-1:0];
    end

    always_comb
    begin
        ctrl.op = cbpa_pkg::DP_NONE;
        unique case (state_reg)
            cbpa_pkg::S_IDLE:       ctrl.op = start ? cbpa_pkg::DP_LATCH : cbpa_pkg::DP_NONE;
            cbpa_pkg::S_ALLOC:      ctrl.op = cbpa_pkg::DP_ALLOC;
            cbpa_pkg::S_FREE_SCAN:  ctrl.op = cbpa_pkg::DP_FREE_CHK;
            cbpa_pkg::S_FREE_SHIFT: ctrl.op = cbpa_pkg::DP_SHIFT;
            cbpa_pkg::S_FREE_DONE:  ctrl.op = cbpa_pkg::DP_FREE_DONE;
            cbpa_pkg::S_FREE_MISS:  ctrl.op = cbpa_pkg::DP_NOT_FOUND;
            cbpa_pkg::S_COMP_SCAN:  ctrl.op = cbpa_pkg::DP_COMP_CHK;
            cbpa_pkg::S_COMP_TURN:  ctrl.op = cbpa_pkg::DP_NONE;
            cbpa_pkg::S_COMP_EMIT:  ctrl.op = cbpa_pkg::DP_COMP_EMIT;
            cbpa_pkg::S_CLOSE:      ctrl.op = cbpa_pkg::DP_CLOSE;
            default:                ctrl.op = cbpa_pkg::DP_NONE;
        endcase
    end

    assign busy = (state_reg != cbpa_pkg::S_IDLE);
    assign idx  = idx_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ({1'b0, idx_reg} < (ADDR_W+1)'(MAX_BLOCKS)))
        else $error("table index out of range");

endmodule

`default_nettype wire

FILE: hdl/cbpa_dp.sv
`default_nettype none

module cbpa_dp #(
    parameter int MAX_BLOCKS  = 32,
    parameter int OFFSET_BITS = 20,
    parameter int ADDR_W      = 5,
    parameter int CNT_W       = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cbpa_pkg::POOL_BITS-1:0]   cfg_wdata,
    input  wire logic [cbpa_pkg::HANDLE_BITS-1:0] handle,
    input  wire logic [cbpa_pkg::POOL_BITS-1:0]   request_bytes,
    input  wire cbpa_pkg::ctrl_t                  ctrl,
    input  wire logic [ADDR_W-1:0]                idx,
    input  wire logic [ADDR_W-1:0]                rd_addr,
    output cbpa_pkg::dp_stat_t                    stat,
    output logic                                  result_strobe,
    output logic [1:0]                            status,
    output logic [cbpa_pkg::HANDLE_BITS-1:0]      result_handle,
    output logic [cbpa_pkg::POOL_BITS-1:0]        data_offset,
    output logic [cbpa_pkg::POOL_BITS-1:0]        free_bytes,
    output logic [cbpa_pkg::POOL_BITS-1:0]        used_bytes,
    output logic [cbpa_pkg::POOL_BITS-1:0]        contiguous_bytes,
    output logic                                  last
);

    localparam int PW = cbpa_pkg::POOL_BITS;
    localparam logic [PW-1:0] OFF_CAP =
        (OFFSET_BITS >= PW) ? {PW{1'b1}} : PW'((1 << OFFSET_BITS) - 1);

    cbpa_pkg::entry_t mem [MAX_BLOCKS];
    cbpa_pkg::entry_t rd_q;
    cbpa_pkg::entry_t wr_data;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [PW-1:0]  pool_reg, free_reg, free_next, used_reg, used_next;
    logic [PW-1:0]  prev_end_reg, prev_end_next, dest_reg, dest_next;
    logic [PW-1:0]  doff_reg, doff_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [MAX_BLOCKS-1:0] moved_reg, moved_next;
    logic [cbpa_pkg::HANDLE_BITS-1:0] handle_reg;
    logic [PW-1:0]  req_reg;

    logic                              emit;
    logic [1:0]                        emit_status;
    logic [cbpa_pkg::HANDLE_BITS-1:0]  emit_handle;
    logic [PW-1:0]                     emit_doff;
    logic                              emit_last;

    logic [PW-1:0] limit;
    logic [PW:0]   total_raw;
    logic [PW+1:0] total_al;
    logic [PW+2:0] alloc_end;
    logic [PW:0]   free_sum;
    logic [PW-1:0] new_off;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    assign stat.empty          = (count_reg == '0);
    assign stat.at_last        = ((CNT_W+1)'(idx) + (CNT_W+1)'(1)) == {1'b0, count_reg};
    assign stat.at_second_last = ((CNT_W+1)'(idx) + (CNT_W+1)'(2)) == {1'b0, count_reg};
    assign stat.match          = (rd_q.owner == handle_reg);

    assign limit     = (pool_reg < OFF_CAP) ? pool_reg : OFF_CAP;
    assign total_raw = {1'b0, req_reg} + {1'b0, cbpa_pkg::HDR_BYTES};
    assign total_al  = ({1'b0, total_raw} + {2'b0, cbpa_pkg::ALIGN_MASK})
                       & ~{2'b0, cbpa_pkg::ALIGN_MASK};
    assign alloc_end = {3'b0, used_reg} + {1'b0, total_al};
    assign free_sum  = {1'b0, free_reg} + {1'b0, rd_q.size};
    assign new_off   = (rd_q.off > dest_reg) ? dest_reg : rd_q.off;

    always_comb
    begin
        free_next     = free_reg;
        used_next     = used_reg;
        prev_end_next = prev_end_reg;
        dest_next     = dest_reg;
        doff_next     = doff_reg;
        count_next    = count_reg;
        moved_next    = moved_reg;
        wr_en         = 1'b0;
        wr_addr       = idx;
        wr_data       = rd_q;
        emit          = 1'b0;
        emit_status   = cbpa_pkg::STAT_OK;
        emit_handle   = handle_reg;
        emit_doff     = '0;
        emit_last     = 1'b1;
        case (ctrl.op)
            cbpa_pkg::DP_LATCH:
            begin
                prev_end_next = '0;
                dest_next     = '0;
                moved_next    = '0;
            end
            cbpa_pkg::DP_ALLOC:
            begin
                emit = 1'b1;
                if (alloc_end > {3'b0, limit})
                    emit_status = cbpa_pkg::STAT_NO_SPACE;
                else if (count_reg >= CNT_W'(MAX_BLOCKS))
                    emit_status = cbpa_pkg::STAT_TABLE_FULL;
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = count_reg[ADDR_W-1:0];
                    wr_data.off   = used_reg;
                    wr_data.size  = total_al[PW-1:0];
                    wr_data.owner = handle_reg;
                    count_next    = count_reg + CNT_W'(1);
                    used_next     = alloc_end[PW-1:0];
                    free_next     = ({2'b0, free_reg} > total_al) ?
                                    free_reg - total_al[PW-1:0] : '0;
                    emit_doff     = used_reg + cbpa_pkg::HDR_BYTES;
                end
            end
            cbpa_pkg::DP_FREE_CHK:
            begin
                if (stat.match)
                begin
                    free_next = (free_sum > {1'b0, pool_reg}) ? pool_reg : free_sum[PW-1:0];
                    doff_next = rd_q.off + cbpa_pkg::HDR_BYTES;
                    if (stat.at_last)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        used_next  = prev_end_reg;
                        emit       = 1'b1;
                        emit_doff  = rd_q.off + cbpa_pkg::HDR_BYTES;
                    end
                end
                else
                begin
                    prev_end_next = rd_q.off + rd_q.size;
                    if (stat.at_last)
                    begin
                        emit        = 1'b1;
                        emit_status = cbpa_pkg::STAT_NOT_FOUND;
                    end
                end
            end
            cbpa_pkg::DP_SHIFT:
            begin
                wr_en = 1'b1;
            end
            cbpa_pkg::DP_FREE_DONE:
            begin
                count_next = count_reg - CNT_W'(1);
                emit       = 1'b1;
                emit_doff  = doff_reg;
            end
            cbpa_pkg::DP_NOT_FOUND:
            begin
                emit        = 1'b1;
                emit_status = cbpa_pkg::STAT_NOT_FOUND;
            end
            cbpa_pkg::DP_COMP_CHK:
            begin
                if (rd_q.off > dest_reg)
                begin
                    wr_en           = 1'b1;
                    wr_data.off     = dest_reg;
                    moved_next[idx] = 1'b1;
                end
                dest_next = new_off + rd_q.size;
                if (stat.at_last)
                    used_next = new_off + rd_q.size;
            end
            cbpa_pkg::DP_COMP_EMIT:
            begin
                emit        = moved_reg[idx];
                emit_handle = rd_q.owner;
                emit_doff   = rd_q.off + cbpa_pkg::HDR_BYTES;
                emit_last   = 1'b0;
            end
            cbpa_pkg::DP_CLOSE:
            begin
                emit = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg      <= cbpa_pkg::POOL_RESET;
            free_reg      <= cbpa_pkg::POOL_RESET;
            used_reg      <= '0;
            count_reg     <= '0;
            result_strobe <= 1'b0;
        end
        else if (cfg_we)
        begin
            pool_reg      <= cfg_wdata;
            free_reg      <= cfg_wdata;
            used_reg      <= '0;
            count_reg     <= '0;
            result_strobe <= 1'b0;
        end
        else
        begin
            free_reg      <= free_next;
            used_reg      <= used_next;
            count_reg     <= count_next;
            result_strobe <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_end_reg <= prev_end_next;
        dest_reg     <= dest_next;
        doff_reg     <= doff_next;
        moved_reg    <= moved_next;
        if (ctrl.op == cbpa_pkg::DP_LATCH)
        begin
            handle_reg <= handle;
            req_reg    <= request_bytes;
        end
        if (emit)
        begin
            status        <= emit_status;
            result_handle <= emit_handle;
            data_offset   <= emit_doff;
            last          <= emit_last;
        end
    end

    assign free_bytes       = free_reg;
    assign used_bytes       = used_reg;
    assign contiguous_bytes = (pool_reg > used_reg) ? pool_reg - used_reg : '0;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_used_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= pool_reg)
        else $error("used end beyond region");

    a_free_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= pool_reg)
        else $error("free bytes above region size");

endmodule

`default_nettype wire
